// ===== rtl/core/voice_allocator_with_stealing_macros.svh =====
// ============================================================================
// Assertion macros for the voice allocator
// Shared helpers that wrap a clocked, reset-qualified concurrent assertion.
// ============================================================================
`ifndef VOICE_ALLOCATOR_WITH_STEALING_MACROS_SVH
`define VOICE_ALLOCATOR_WITH_STEALING_MACROS_SVH

// Checks an implication on the rising clock edge, held off while reset is low.
`define VAWS_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, using the block's standard clock and reset names.
`define VAWS_ASSERT(lbl, prop, msg) \
    `VAWS_ASSERT_CLK(lbl, i_clk, i_rst_n, prop, msg)

`endif

// ===== rtl/core/vaws_pkg.sv =====
// ============================================================================
// vaws_pkg
// Types and constants shared by the voice allocator and its voice cells.
// ============================================================================
package vaws_pkg;

    // Largest supported voice table and the widths that follow from it.
    localparam int VA_MAX_VOICES = 64;
    localparam int VA_IDX_W      = 6;
    localparam int VA_CNT_W      = 7;

    // Field widths of a request and a result.
    localparam int VA_PRIO_W  = 8;
    localparam int VA_GROUP_W = 16;
    localparam int VA_LIMIT_W = 10;
    localparam int VA_VIDX_W  = 5;

    // Configuration port layout: one register per 32-bit word.
    localparam int        CFG_ADDR_W      = 3;
    localparam int        CFG_DATA_W      = 32;
    localparam logic      CFG_IDX_ENABLED = 1'b0;

    // Request kinds.
    typedef enum logic {
        REQ_PLAY     = 1'b0,
        REQ_FINISHED = 1'b1
    } t_req_type;

    // Controller states.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Request marks broadcast to every cell.
    typedef struct packed {
        logic                  absl;
        logic [VA_PRIO_W-1:0]  prio;
        logic [VA_GROUP_W-1:0] grp;
    } t_req;

    // Table update command broadcast to every cell.
    typedef struct packed {
        logic                wr;
        logic                clr;
        logic [VA_IDX_W-1:0] idx;
    } t_cell_cmd;

    // Scan token handed from cell to cell.
    typedef struct packed {
        logic                valid;
        logic [VA_CNT_W-1:0] count;
        logic                found_a;
        logic [VA_IDX_W-1:0] pick_a;
        logic                stop_a;
        logic                found_b;
        logic [VA_IDX_W-1:0] pick_b;
        logic                stop_b;
    } t_scan_tok;

endpackage

// ===== rtl/core/vaws_cell.sv =====
// ============================================================================
// vaws_cell
// One voice of the table: holds its marks, updates its part of the scan
// token and registers it on its way to the next cell.
// ============================================================================
module vaws_cell
    import vaws_pkg::*;
#(
    parameter int CellIdx = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req      i_req,
    input  t_cell_cmd i_cmd,
    input  t_scan_tok i_tok,
    output t_scan_tok o_tok
);

    localparam logic [VA_IDX_W-1:0] MY_IDX = VA_IDX_W'(CellIdx);

    logic                  r_playing;
    logic                  r_absolute;
    logic [VA_PRIO_W-1:0]  r_priority;
    logic [VA_GROUP_W-1:0] r_group;
    t_scan_tok             r_tok;
    t_scan_tok             n_tok;

    logic in_group;
    logic stealable;
    logic cand_free;
    logic cand_group;
    logic hit;

    // Local view of this voice against the request being scanned.
    assign in_group   = r_playing && (r_group == i_req.grp);
    assign stealable  = !r_absolute && (i_req.prio >= r_priority);
    assign cand_free  = !r_playing || stealable;
    assign cand_group = in_group && stealable;
    assign hit        = (i_cmd.idx == MY_IDX);

    // Add this voice to the group count and claim the first-candidate slots.
    always_comb begin
        n_tok       = i_tok;
        n_tok.count = i_tok.count + VA_CNT_W'(in_group);
        if (!i_tok.found_a && cand_free) begin
            n_tok.found_a = 1'b1;
            n_tok.pick_a  = MY_IDX;
            n_tok.stop_a  = r_playing;
        end
        if (!i_tok.found_b && cand_group) begin
            n_tok.found_b = 1'b1;
            n_tok.pick_b  = MY_IDX;
            n_tok.stop_b  = r_playing;
        end
    end

    // Token stage toward the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

    // Voice marks: a grant loads the request, a finished event stops the voice.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing  <= 1'b0;
            r_absolute <= 1'b0;
            r_priority <= '0;
            r_group    <= '0;
        end else if (i_cmd.wr && hit) begin
            r_playing  <= 1'b1;
            r_absolute <= i_req.absl;
            r_priority <= i_req.prio;
            r_group    <= i_req.grp;
        end else if (i_cmd.clr && hit) begin
            r_playing  <= 1'b0;
        end
    end

endmodule

// ===== rtl/core/voice_allocator_with_stealing.sv =====
// ============================================================================
// voice_allocator_with_stealing
// Voice allocator with group limits and priority stealing, built as a row
// of voice cells that a scan token walks through one cell per cycle.
// ============================================================================
//
//  Channel   Handshake                Payload
//  --------  -----------------------  -------------------------------------
//  request   start / busy             i_req_type, i_is_absolute,
//                                     i_priority_req, i_group,
//                                     i_group_limit, i_finished_voice
//  result    o_valid (one cycle)      o_granted, o_voice_index, o_must_stop
//  config    APB psel/penable/pready  paddr, pwdata, prdata
//
//  A finished event, or a play request while disabled, gives its result
//  in the cycle after it is taken and keeps busy low.
//  An enabled play request holds busy while the scan token passes every
//  voice cell in turn, one cell per clock; the pick and table update
//  happen as the token comes out of the last cell.
//  Reset is synchronous and active low; it empties the table and enables
//  the block. The receiver cannot stall, so results are never held back.
//
module voice_allocator_with_stealing
    import vaws_pkg::*;
#(
    parameter int NUM_VOICES = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Request channel.
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_req_type,
    input  logic                         i_is_absolute,
    input  logic [VA_PRIO_W-1:0]         i_priority_req,
    input  logic signed [VA_GROUP_W-1:0] i_group,
    input  logic [VA_LIMIT_W-1:0]        i_group_limit,
    input  logic [VA_VIDX_W-1:0]         i_finished_voice,

    // Result channel.
    output logic                         o_valid,
    output logic                         o_granted,
    output logic [VA_VIDX_W-1:0]         o_voice_index,
    output logic                         o_must_stop,

    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready
);

    t_state                  r_state;
    t_state                  n_state;
    logic                    r_inject;
    logic                    n_inject;
    logic                    r_enabled;
    t_req                    r_req;
    logic [VA_LIMIT_W-1:0]   r_limit;

    logic                    r_valid;
    logic                    n_valid;
    logic                    r_granted;
    logic                    n_granted;
    logic [VA_VIDX_W-1:0]    r_voice_index;
    logic [VA_VIDX_W-1:0]    n_voice_index;
    logic                    r_must_stop;
    logic                    n_must_stop;

    t_cell_cmd               cmd;
    t_scan_tok               tok [NUM_VOICES+1];
    t_scan_tok               tok_end;
    logic                    accept;
    logic                    below_limit;
    logic                    sel_found;
    logic [VA_IDX_W-1:0]     sel_pick;
    logic                    sel_stop;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;

    // Configuration register: written on the APB access phase.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b1;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[CFG_ADDR_W-1] == CFG_IDX_ENABLED)) begin
            r_enabled <= pwdata[0];
        end
    end

    assign prdata = (paddr[CFG_ADDR_W-1] == CFG_IDX_ENABLED) ?
                    {{(CFG_DATA_W-1){1'b0}}, r_enabled} : '0;

    // Request marks are held for the whole scan and the final update.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.absl <= i_is_absolute;
            r_req.prio <= i_priority_req;
            r_req.grp  <= i_group;
            r_limit    <= i_group_limit;
        end
    end

    // The scan token enters the first cell with an empty count.
    assign tok[0] = {r_inject, {($bits(t_scan_tok)-1){1'b0}}};

    // Row of voice cells.
    for (genvar gi = 0; gi < NUM_VOICES; gi++) begin : g_cell
        vaws_cell #(
            .CellIdx (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_req   (r_req),
            .i_cmd   (cmd),
            .i_tok   (tok[gi]),
            .o_tok   (tok[gi+1])
        );
    end

    assign tok_end = tok[NUM_VOICES];

    // Pick between a free or stealable voice and stealing inside the group.
    assign below_limit = (VA_LIMIT_W'(tok_end.count) < r_limit);
    assign sel_found   = below_limit ? tok_end.found_a : tok_end.found_b;
    assign sel_pick    = below_limit ? tok_end.pick_a  : tok_end.pick_b;
    assign sel_stop    = below_limit ? tok_end.stop_a  : tok_end.stop_b;

    // Controller: next state, table commands and the next result.
    always_comb begin
        n_state       = r_state;
        n_inject      = 1'b0;
        n_valid       = 1'b0;
        n_granted     = 1'b0;
        n_voice_index = '0;
        n_must_stop   = 1'b0;
        cmd           = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_req_type == REQ_FINISHED) begin
                        cmd.clr = 1'b1;
                        cmd.idx = VA_IDX_W'(i_finished_voice);
                        n_valid = 1'b1;
                    end else if (!r_enabled) begin
                        n_valid = 1'b1;
                    end else begin
                        n_state  = ST_SCAN;
                        n_inject = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                if (tok_end.valid) begin
                    n_state = ST_IDLE;
                    n_valid = 1'b1;
                    if (sel_found) begin
                        n_granted     = 1'b1;
                        n_voice_index = sel_pick[VA_VIDX_W-1:0];
                        n_must_stop   = sel_stop;
                        cmd.wr        = 1'b1;
                        cmd.idx       = sel_pick;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_inject <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_inject <= n_inject;
            r_valid  <= n_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_granted     <= n_granted;
        r_voice_index <= n_voice_index;
        r_must_stop   <= n_must_stop;
    end

    assign o_valid       = r_valid;
    assign o_granted     = r_granted;
    assign o_voice_index = r_voice_index;
    assign o_must_stop   = r_must_stop;

endmodule

// ===== rtl/core/vaws_checker.sv =====
// ============================================================================
// vaws_checker
// Port-level checks on the voice allocator's request and result timing.
// ============================================================================
`include "voice_allocator_with_stealing_macros.svh"

module vaws_checker
    import vaws_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 i_req_type,
    input logic                 o_valid,
    input logic                 o_granted,
    input logic [VA_VIDX_W-1:0] o_voice_index,
    input logic                 o_must_stop
);

    logic take;
    logic take_fin;
    logic blank_res;

    // A request is taken, and whether it is a finished event.
    assign take      = start && !busy;
    assign take_fin  = take && (i_req_type == REQ_FINISHED);
    assign blank_res = (o_voice_index == '0) && !o_must_stop;

    // A result only appears once the block has finished its scan.
    `VAWS_ASSERT(a_result_when_free, o_valid |-> !busy, "result while busy")

    // A finished event answers in the next cycle and never grants.
    `VAWS_ASSERT(a_finished_answer, take_fin |=> (o_valid && !o_granted), "finish unanswered")

    // A taken request either starts a scan or answers at once.
    `VAWS_ASSERT(a_request_progress, take |=> (busy || o_valid), "request dropped")

    // Without a grant there is no voice and nothing to stop.
    `VAWS_ASSERT(a_no_grant_zero, (o_valid && !o_granted) |-> blank_res, "stray grant data")

endmodule

bind voice_allocator_with_stealing vaws_checker u_vaws_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_req_type    (i_req_type),
    .o_valid       (o_valid),
    .o_granted     (o_granted),
    .o_voice_index (o_voice_index),
    .o_must_stop   (o_must_stop)
);
